>>> rtl/bhc_pkg.sv
// Shared constants, types and codes for the barcode Hamming classifier.
package bhc_pkg;

    localparam int MAX_SAMPLES     = 16;
    localparam int MAX_BARCODE_LEN = 16;
    localparam int SLOT_W          = 4;
    localparam int POS_W           = 4;
    localparam int BYTE_W          = 8;
    localparam int CNT_W           = 5;
    localparam int CFG_W           = 5;
    localparam int NSAMP_W         = $clog2(MAX_SAMPLES + 1);
    localparam int BPOS_W          = POS_W + 1;
    localparam int CNT_MAX         = (1 << CNT_W) - 1;
    localparam int DEFAULT_LENGTH  = 6;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int REG_IDX_W       = APB_ADDR_W - 2;

    typedef logic [1:0]         t_mode;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [BPOS_W-1:0]  t_bpos;
    typedef logic [NSAMP_W-1:0] t_nsamp;
    typedef logic [4:0]         t_sample;
    typedef logic [1:0]         t_outcome;

    localparam t_mode MODE_BYTE  = 2'd0;
    localparam t_mode MODE_LIMIT = 2'd1;
    localparam t_mode MODE_BASE  = 2'd2;

    localparam t_outcome OUT_ASSIGNED   = 2'd0;
    localparam t_outcome OUT_NO_SAMPLES = 2'd1;
    localparam t_outcome OUT_TIED       = 2'd2;
    localparam t_outcome OUT_OVER_LIMIT = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BARCODE_LEN  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PEND
    } t_state;

    typedef struct packed {
        logic  wr_byte;
        logic  wr_limit;
        logic  base;
        logic  last;
        t_slot slot;
        t_pos  position;
        t_byte value;
        t_bpos base_pos;
    } t_cell_ctl;

    typedef struct packed {
        logic  valid;
        logic  found;
        logic  tied;
        t_cnt  best;
        t_slot slot;
        t_cnt  limit;
    } t_wave;

endpackage

>>> rtl/bhc_if.sv
// Request channel interfaces for index input items and classification results.
interface bhc_in_if;
    import bhc_pkg::*;

    logic  valid;
    logic  ready;
    t_mode mode;
    t_slot slot;
    t_pos  position;
    t_byte value;

    modport source (output valid, output mode, output slot, output position,
                    output value, input ready);
    modport sink   (input valid, input mode, input slot, input position,
                    input value, output ready);
endinterface

interface bhc_out_if;
    import bhc_pkg::*;

    logic     valid;
    logic     ready;
    t_sample  sample;
    t_cnt     best_distance;
    t_outcome outcome;

    modport source (output valid, output sample, output best_distance,
                    output outcome, input ready);
    modport sink   (input valid, input sample, input best_distance,
                    input outcome, output ready);
endinterface

>>> rtl/bhc_cell.sv
// One sample cell: barcode row, limit, mismatch counter and one step of the best-match scan.
module bhc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bhc_pkg::t_slot     i_index,
    input  bhc_pkg::t_nsamp    i_samples,
    input  bhc_pkg::t_cell_ctl i_ctl,
    input  bhc_pkg::t_wave     i_wave,
    output bhc_pkg::t_wave     o_wave
);
    import bhc_pkg::*;

    t_byte r_row [MAX_BARCODE_LEN];
    t_cnt  r_limit;
    t_cnt  r_count;
    t_cnt  n_count;
    t_cnt  r_snap;
    t_wave r_wave;
    t_wave n_wave;
    logic  sel;
    logic  in_range;
    logic  miss;
    logic  active;

    assign sel      = (i_ctl.slot == i_index);
    assign in_range = (i_ctl.base_pos < BPOS_W'(MAX_BARCODE_LEN));
    assign miss     = in_range && (r_row[i_ctl.base_pos[POS_W-1:0]] != i_ctl.value);
    assign active   = ({1'b0, i_index} < i_samples);

    always_comb begin
        n_count = r_count;
        if (i_ctl.base && miss && (r_count != CNT_W'(CNT_MAX))) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_byte && sel) begin
            r_row[i_ctl.position] <= i_ctl.value;
        end
        if (i_ctl.wr_limit && sel) begin
            r_limit <= (i_ctl.value > BYTE_W'(CNT_MAX)) ? CNT_W'(CNT_MAX)
                                                         : i_ctl.value[CNT_W-1:0];
        end
        if (i_ctl.base && i_ctl.last) begin
            r_snap <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.base) begin
            r_count <= i_ctl.last ? '0 : n_count;
        end
    end

    always_comb begin
        n_wave = i_wave;
        if (i_wave.valid && active) begin
            if (r_snap < i_wave.best) begin
                n_wave.best  = r_snap;
                n_wave.slot  = i_index;
                n_wave.found = 1'b1;
                n_wave.tied  = 1'b0;
                n_wave.limit = r_limit;
            end else if (r_snap == i_wave.best) begin
                n_wave.tied = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= n_wave.valid;
        end
        r_wave.found <= n_wave.found;
        r_wave.tied  <= n_wave.tied;
        r_wave.best  <= n_wave.best;
        r_wave.slot  <= n_wave.slot;
        r_wave.limit <= n_wave.limit;
    end

    assign o_wave = r_wave;

endmodule

>>> rtl/barcode_hamming_classifier.sv
// Top level of the barcode Hamming classifier: control, configuration port and cell chain.
//
// Index bases and loads are taken one per cycle while the block is idle; every sample cell
// compares the base with its barcode byte and counts mismatches in the same cycle. On the
// last base of a read the block stops taking requests while the best-match scan travels
// down the chain of MAX_SAMPLES cells, one cell per cycle, and then hands its result
// through the pending register to the output register; the next request is accepted once
// the output register is free. A result waits in the output register while the next read
// streams in.
module barcode_hamming_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bhc_in_if.sink                          i_in,
    bhc_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bhc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bhc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bhc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import bhc_pkg::*;

    logic [CFG_W-1:0]     r_sample_count;
    logic [CFG_W-1:0]     r_barcode_len;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    t_state    r_state;
    t_state    n_state;
    t_bpos     r_base_pos;
    t_bpos     n_base_pos;
    t_cnt      eff_len;
    t_nsamp    eff_samples;
    t_cell_ctl ctl;
    t_wave     r_seed;
    t_wave     wave [MAX_SAMPLES+1];
    logic      in_acc;
    logic      base_acc;
    logic      read_done;
    logic      out_free;
    logic      out_load;

    t_sample   r_pend_sample;
    t_cnt      r_pend_best;
    t_outcome  r_pend_outcome;
    t_sample   n_pend_sample;
    t_outcome  n_pend_outcome;
    logic      r_out_valid;
    t_sample   r_out_sample;
    t_cnt      r_out_best;
    t_outcome  r_out_outcome;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_barcode_len  <= CFG_W'(DEFAULT_LENGTH);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SAMPLE_COUNT: r_sample_count <= pwdata[CFG_W-1:0];
                REG_BARCODE_LEN:  r_barcode_len  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SAMPLE_COUNT: prdata = APB_DATA_W'(r_sample_count);
            REG_BARCODE_LEN:  prdata = APB_DATA_W'(r_barcode_len);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_barcode_len == '0) begin
            eff_len = CNT_W'(1);
        end else if (r_barcode_len > CFG_W'(MAX_BARCODE_LEN)) begin
            eff_len = CNT_W'(MAX_BARCODE_LEN);
        end else begin
            eff_len = CNT_W'(r_barcode_len);
        end
        if (r_sample_count > CFG_W'(MAX_SAMPLES)) begin
            eff_samples = NSAMP_W'(MAX_SAMPLES);
        end else begin
            eff_samples = NSAMP_W'(r_sample_count);
        end
    end

    // Request decoding and base position.
    assign in_acc     = i_in.valid && i_in.ready;
    assign base_acc   = in_acc && (i_in.mode == MODE_BASE);
    assign n_base_pos = r_base_pos + BPOS_W'(1);
    assign read_done  = base_acc && (BPOS_W'(n_base_pos) >= BPOS_W'(eff_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pos <= '0;
        end else if (base_acc) begin
            r_base_pos <= read_done ? '0 : n_base_pos;
        end
    end

    always_comb begin
        ctl.wr_byte  = in_acc && (i_in.mode == MODE_BYTE);
        ctl.wr_limit = in_acc && (i_in.mode == MODE_LIMIT);
        ctl.base     = base_acc;
        ctl.last     = read_done;
        ctl.slot     = i_in.slot;
        ctl.position = i_in.position;
        ctl.value    = i_in.value;
        ctl.base_pos = r_base_pos;
    end

    // Scan seed is registered from the last base and enters the chain in the cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed.valid <= 1'b0;
        end else begin
            r_seed.valid <= read_done;
        end
        if (read_done) begin
            r_seed.found <= 1'b0;
            r_seed.tied  <= 1'b0;
            r_seed.best  <= eff_len + CNT_W'(1);
            r_seed.slot  <= '0;
            r_seed.limit <= '0;
        end
    end

    assign wave[0] = r_seed;

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        bhc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_index   (SLOT_W'(g)),
            .i_samples (eff_samples),
            .i_ctl     (ctl),
            .i_wave    (wave[g]),
            .o_wave    (wave[g+1])
        );
    end

    // Control state machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (read_done)                    n_state = ST_SCAN;
            ST_SCAN: if (wave[MAX_SAMPLES].valid)      n_state = ST_PEND;
            ST_PEND: if (out_free)                     n_state = ST_IDLE;
            default:                                   n_state = ST_IDLE;
        endcase
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_SCAN: ;
            ST_PEND: out_load = out_free;
            default: ;
        endcase
    end

    // Final decision from the scan.
    always_comb begin
        n_pend_sample = '0;
        priority if (!wave[MAX_SAMPLES].found) begin
            n_pend_outcome = OUT_NO_SAMPLES;
        end else if (wave[MAX_SAMPLES].tied) begin
            n_pend_outcome = OUT_TIED;
        end else if (wave[MAX_SAMPLES].best > wave[MAX_SAMPLES].limit) begin
            n_pend_outcome = OUT_OVER_LIMIT;
        end else begin
            n_pend_outcome = OUT_ASSIGNED;
            n_pend_sample  = $bits(t_sample)'(wave[MAX_SAMPLES].slot) + $bits(t_sample)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wave[MAX_SAMPLES].valid) begin
            r_pend_sample  <= n_pend_sample;
            r_pend_best    <= wave[MAX_SAMPLES].best;
            r_pend_outcome <= n_pend_outcome;
        end
        if (out_load) begin
            r_out_sample  <= r_pend_sample;
            r_out_best    <= r_pend_best;
            r_out_outcome <= r_pend_outcome;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample        = r_out_sample;
    assign o_out.best_distance = r_out_best;
    assign o_out.outcome       = r_out_outcome;

endmodule
